// ===== src/sorted_priority_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_defines
// Assertion macros shared by the sorted priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH   = 64;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 7;
  localparam int VAL_W   = 32;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic                    load;
    opcode_t                 op;
    logic signed [VAL_W-1:0] value;
  } spq_cmd_t;

endpackage

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted array. Compares the broadcast value with its own
// entry and takes its own, its neighbor's or the new value on each beat.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                           clk,
  input  spq_pkg::spq_cmd_t              cmd,
  input  logic                           occupied,
  input  logic                           tail,
  input  logic signed [spq_pkg::VAL_W-1:0] prev_value,
  input  logic                           prev_greater,
  input  logic signed [spq_pkg::VAL_W-1:0] next_value,
  output logic signed [spq_pkg::VAL_W-1:0] value,
  output logic                           greater
);
  import spq_pkg::*;

  logic signed [VAL_W-1:0] entry;
  logic signed [VAL_W-1:0] entry_next;

  assign greater = occupied && (entry > cmd.value);
  assign value   = entry;

  always_comb begin
    entry_next = entry;
    case (cmd.op)
      OP_INSERT: begin
        if (prev_greater) begin
          entry_next = prev_value;
        end else if (greater || tail) begin
          entry_next = cmd.value;
        end
      end
      OP_DELETE: begin
        entry_next = next_value;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry <= entry_next;
    end
  end

endmodule

// ===== src/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Min priority queue over a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries opcode and value: insert places
// the value behind every stored value less than or equal to it, delete takes
// the smallest entry. Every input beat yields one output beat (out_valid/
// out_ready) with status, out_value and count.
// The result is registered and appears in the cycle after the input beat.
// Throughput: one beat per cycle while the receiver keeps up; every cell
// compares against the broadcast value and shifts in the same cycle.
// Full insert returns overflow, empty delete returns underflow; neither
// changes the stored data. out_value is zero unless a delete succeeds.
// Reset clears the occupancy and the output valid; entries above the occupancy are
// never read. When the receiver stalls, the output register holds its beat
// and in_ready drops until it is taken; a new input beat is accepted in the
// same cycle that the waiting result leaves.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             opcode,
  input  logic signed [spq_pkg::VAL_W-1:0]   value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic signed [spq_pkg::VAL_W-1:0]   out_value,
  output logic [spq_pkg::COUNT_W-1:0]        count
);
  import spq_pkg::*;

  logic [CNT_W-1:0]         occ;
  logic [CNT_W-1:0]         occ_next;
  logic                     accept;
  logic                     full;
  logic                     empty;
  status_t                  st;
  spq_cmd_t                 cmd;
  logic signed [VAL_W-1:0]  cell_value   [DEPTH];
  logic                     cell_greater [DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (occ == CNT_W'(DEPTH));
  assign empty    = (occ == '0);

  always_comb begin
    if (opcode == OP_INSERT) begin
      st = full ? ST_OVERFLOW : ST_OK;
    end else begin
      st = empty ? ST_UNDERFLOW : ST_OK;
    end
  end

  assign cmd.load  = accept && (st == ST_OK);
  assign cmd.op    = opcode_t'(opcode);
  assign cmd.value = value;

  always_comb begin
    occ_next = occ;
    if (cmd.load) begin
      if (cmd.op == OP_INSERT) begin
        occ_next = occ + 1'b1;
      end else begin
        occ_next = occ - 1'b1;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] prev_v;
    logic                    prev_g;
    logic signed [VAL_W-1:0] next_v;

    if (i == 0) begin : g_head
      assign prev_v = '0;
      assign prev_g = 1'b0;
    end else begin : g_body
      assign prev_v = cell_value[i-1];
      assign prev_g = cell_greater[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = cell_value[i];
    end else begin : g_mid
      assign next_v = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .occupied     (CNT_W'(i) < occ),
      .tail         (CNT_W'(i) == occ),
      .prev_value   (prev_v),
      .prev_greater (prev_g),
      .next_value   (next_v),
      .value        (cell_value[i]),
      .greater      (cell_greater[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      occ <= occ_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= st;
      out_value <= (cmd.load && cmd.op == OP_DELETE) ? cell_value[0] : '0;
      count     <= COUNT_W'(occ_next);
    end
  end

  `SPQ_ASSERT_SAME(a_occ_range, 1'b1, occ <= CNT_W'(DEPTH), "occupancy above depth")
  `SPQ_ASSERT_SAME(a_ovf_full, out_valid && status == ST_OVERFLOW,
                   count == COUNT_W'(DEPTH), "overflow reported while not full")
  `SPQ_ASSERT_SAME(a_unf_empty, out_valid && status == ST_UNDERFLOW,
                   count == '0 && out_value == '0, "underflow with data or count")
  `SPQ_ASSERT_NEXT(a_del_count, accept && cmd.load && cmd.op == OP_DELETE,
                   occ == $past(occ) - 1'b1, "delete did not drop occupancy")
  `SPQ_ASSERT_SAME(a_head_sorted, occ >= CNT_W'(2),
                   cell_value[0] <= cell_value[1], "head entries out of order")

endmodule
